// ===== hw/rtl/lik_pkg.sv =====
// lik_pkg: shared types and constants for the leg inverse kinematics block
// request and response payload structs, register indexes, cordic step angles
// no dependencies
package lik_pkg;

   typedef struct packed {
      logic [1:0]          leg_select;
      logic signed [15:0]  x_pos;
      logic signed [15:0]  z_pos;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]          leg_number;
      logic signed [31:0]  motor_first;
      logic signed [31:0]  motor_second;
      logic                saturated;
   } rsp_payload_type;

   localparam int CSR_INDEX_WIDTH = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_UPPER_LINK = 3'd0,
      CSR_LOWER_LINK = 3'd1,
      CSR_MIN_LENGTH = 3'd2,
      CSR_MAX_LENGTH = 3'd3,
      CSR_GEAR_RATIO = 3'd4
   } csr_index_type;

   // unit ratio in q.16 plus one integer bit
   localparam int QUOT_WIDTH = 17;
   localparam logic [QUOT_WIDTH-1:0] ONE_Q16 = 17'd65536;

   localparam int STEP_WIDTH = 22;

   // atan(2^-i) in degrees, q.16, rounded to nearest
   function automatic logic [STEP_WIDTH-1:0] step_angle(input int idx);
      logic [STEP_WIDTH-1:0] a;
      case (idx)
         0:       a = 22'd2949120;
         1:       a = 22'd1740967;
         2:       a = 22'd919879;
         3:       a = 22'd466945;
         4:       a = 22'd234379;
         5:       a = 22'd117304;
         6:       a = 22'd58666;
         7:       a = 22'd29335;
         8:       a = 22'd14668;
         9:       a = 22'd7334;
         10:      a = 22'd3667;
         11:      a = 22'd1833;
         12:      a = 22'd917;
         13:      a = 22'd458;
         14:      a = 22'd229;
         15:      a = 22'd115;
         16:      a = 22'd57;
         17:      a = 22'd29;
         18:      a = 22'd14;
         19:      a = 22'd7;
         20:      a = 22'd4;
         21:      a = 22'd2;
         22:      a = 22'd1;
         default: a = 22'd0;
      endcase
      return a;
   endfunction

endpackage

// ===== hw/rtl/lik_isqrt.sv =====
// lik_isqrt: pipelined integer square root, one result bit per cell
// restoring digit recurrence over LANES independent lanes with a carried sideband
// no dependencies
module lik_isqrt #(
   parameter int LANES = 1,
   parameter int IW    = 32,
   parameter int SW    = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [LANES-1:0][IW-1:0]      in_rad,
   input  logic [SW-1:0]                 in_side,
   output logic                          out_valid,
   output logic [LANES-1:0][IW/2-1:0]    out_root,
   output logic [SW-1:0]                 out_side
);

   localparam int HW = IW / 2;
   localparam int RW = HW + 1;

   logic                         valid_st [HW+1];
   logic [LANES-1:0][IW-1:0]     rad_st   [HW+1];
   logic [LANES-1:0][RW-1:0]     rem_st   [HW+1];
   logic [LANES-1:0][HW-1:0]     root_st  [HW+1];
   logic [SW-1:0]                side_st  [HW+1];

   assign valid_st[0] = in_valid;
   assign rad_st[0]   = in_rad;
   assign rem_st[0]   = '0;
   assign root_st[0]  = '0;
   assign side_st[0]  = in_side;

   for (genvar k = 0; k < HW; k++) begin : g_cell
      logic [LANES-1:0][RW+1:0]  cur;
      logic [LANES-1:0][RW+1:0]  sub;
      logic [LANES-1:0]          ge;
      logic [LANES-1:0][IW-1:0]  rad_in;
      logic [LANES-1:0][RW-1:0]  rem_in;
      logic [LANES-1:0][HW-1:0]  root_in;
      logic                      valid_ff;
      logic [LANES-1:0][IW-1:0]  rad_ff;
      logic [LANES-1:0][RW-1:0]  rem_ff;
      logic [LANES-1:0][HW-1:0]  root_ff;
      logic [SW-1:0]             side_ff;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            cur[l]     = {rem_st[k][l], rad_st[k][l][IW-1 -: 2]};
            sub[l]     = {1'b0, root_st[k][l], 2'b01};
            ge[l]      = (cur[l] >= sub[l]);
            rem_in[l]  = ge[l] ? RW'(cur[l] - sub[l]) : cur[l][RW-1:0];
            root_in[l] = {root_st[k][l][HW-2:0], ge[l]};
            rad_in[l]  = rad_st[k][l] << 2;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_st[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff  <= rad_in;
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= side_st[k];
         end
      end

      assign valid_st[k+1] = valid_ff;
      assign rad_st[k+1]   = rad_ff;
      assign rem_st[k+1]   = rem_ff;
      assign root_st[k+1]  = root_ff;
      assign side_st[k+1]  = side_ff;
   end

   assign out_valid = valid_st[HW];
   assign out_root  = root_st[HW];
   assign out_side  = side_st[HW];

endmodule

// ===== hw/rtl/lik_div.sv =====
// lik_div: pipelined unsigned ratio mag/den in q.16, one quotient bit per cell
// flags quotients of two or more up front; depends on lik_pkg
module lik_div #(
   parameter int LANES = 2,
   parameter int W     = 33,
   parameter int SW    = 1
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    en,
   input  logic                                    in_valid,
   input  logic [LANES-1:0][W-1:0]                 in_mag,
   input  logic [LANES-1:0][W-1:0]                 in_den,
   input  logic [SW-1:0]                           in_side,
   output logic                                    out_valid,
   output logic [LANES-1:0][lik_pkg::QUOT_WIDTH-1:0] out_quot,
   output logic [LANES-1:0]                        out_ovf,
   output logic [SW-1:0]                           out_side
);
   import lik_pkg::*;

   localparam int RW = W + 16;
   localparam int CW = W + 17;

   logic                               valid_st [QUOT_WIDTH+1];
   logic [LANES-1:0][RW-1:0]           rem_st   [QUOT_WIDTH+1];
   logic [LANES-1:0][W-1:0]            den_st   [QUOT_WIDTH+1];
   logic [LANES-1:0][QUOT_WIDTH-1:0]   quot_st  [QUOT_WIDTH+1];
   logic [LANES-1:0]                   ovf_st   [QUOT_WIDTH+1];
   logic [SW-1:0]                      side_st  [QUOT_WIDTH+1];

   for (genvar l = 0; l < LANES; l++) begin : g_in
      assign rem_st[0][l] = {in_mag[l], 16'd0};
      assign ovf_st[0][l] = ({1'b0, in_mag[l]} >= {in_den[l], 1'b0});
   end

   assign valid_st[0] = in_valid;
   assign den_st[0]   = in_den;
   assign quot_st[0]  = '0;
   assign side_st[0]  = in_side;

   for (genvar j = 0; j < QUOT_WIDTH; j++) begin : g_cell
      localparam int K = QUOT_WIDTH - 1 - j;
      logic [LANES-1:0][CW-1:0]          shifted;
      logic [LANES-1:0]                  ge;
      logic [LANES-1:0][RW-1:0]          rem_in;
      logic [LANES-1:0][QUOT_WIDTH-1:0]  quot_in;
      logic                              valid_ff;
      logic [LANES-1:0][RW-1:0]          rem_ff;
      logic [LANES-1:0][W-1:0]           den_ff;
      logic [LANES-1:0][QUOT_WIDTH-1:0]  quot_ff;
      logic [LANES-1:0]                  ovf_ff;
      logic [SW-1:0]                     side_ff;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            shifted[l]    = CW'(den_st[j][l]) << K;
            ge[l]         = ({1'b0, rem_st[j][l]} >= shifted[l]);
            rem_in[l]     = ge[l] ? RW'({1'b0, rem_st[j][l]} - shifted[l]) : rem_st[j][l];
            quot_in[l]    = quot_st[j][l];
            quot_in[l][K] = ge[l];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_st[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            den_ff  <= den_st[j];
            quot_ff <= quot_in;
            ovf_ff  <= ovf_st[j];
            side_ff <= side_st[j];
         end
      end

      assign valid_st[j+1] = valid_ff;
      assign rem_st[j+1]   = rem_ff;
      assign den_st[j+1]   = den_ff;
      assign quot_st[j+1]  = quot_ff;
      assign ovf_st[j+1]   = ovf_ff;
      assign side_st[j+1]  = side_ff;
   end

   assign out_valid = valid_st[QUOT_WIDTH];
   assign out_quot  = quot_st[QUOT_WIDTH];
   assign out_ovf   = ovf_st[QUOT_WIDTH];
   assign out_side  = side_st[QUOT_WIDTH];

endmodule

// ===== hw/rtl/lik_cordic.sv =====
// lik_cordic: pipelined vectoring cordic, one rotation per cell
// gives atan2(y, x) in degrees q.16 for x >= 0; depends on lik_pkg
module lik_cordic #(
   parameter int LANES = 2,
   parameter int ITER  = 16,
   parameter int XW    = 20,
   parameter int ZW    = 24,
   parameter int SW    = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic signed [XW-1:0]  in_x [LANES],
   input  logic signed [XW-1:0]  in_y [LANES],
   input  logic [SW-1:0]         in_side,
   output logic                  out_valid,
   output logic signed [ZW-1:0]  out_z [LANES],
   output logic [SW-1:0]         out_side
);
   import lik_pkg::*;

   logic                  valid_st [ITER+1];
   logic signed [XW-1:0]  x_st     [ITER+1][LANES];
   logic signed [XW-1:0]  y_st     [ITER+1][LANES];
   logic signed [ZW-1:0]  z_st     [ITER+1][LANES];
   logic [SW-1:0]         side_st  [ITER+1];

   assign valid_st[0] = in_valid;
   assign side_st[0]  = in_side;

   for (genvar l = 0; l < LANES; l++) begin : g_in
      assign x_st[0][l] = in_x[l];
      assign y_st[0][l] = in_y[l];
      assign z_st[0][l] = '0;
      assign out_z[l]   = z_st[ITER][l];
   end

   for (genvar i = 0; i < ITER; i++) begin : g_cell
      localparam logic signed [ZW-1:0] ANG = ZW'(step_angle(i));
      logic signed [XW-1:0]  x_in [LANES];
      logic signed [XW-1:0]  y_in [LANES];
      logic signed [ZW-1:0]  z_in [LANES];
      logic signed [XW-1:0]  x_ff [LANES];
      logic signed [XW-1:0]  y_ff [LANES];
      logic signed [ZW-1:0]  z_ff [LANES];
      logic                  valid_ff;
      logic [SW-1:0]         side_ff;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (!y_st[i][l][XW-1]) begin
               x_in[l] = x_st[i][l] + (y_st[i][l] >>> i);
               y_in[l] = y_st[i][l] - (x_st[i][l] >>> i);
               z_in[l] = z_st[i][l] + ANG;
            end else begin
               x_in[l] = x_st[i][l] - (y_st[i][l] >>> i);
               y_in[l] = y_st[i][l] + (x_st[i][l] >>> i);
               z_in[l] = z_st[i][l] - ANG;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= valid_st[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff    <= x_in;
            y_ff    <= y_in;
            z_ff    <= z_in;
            side_ff <= side_st[i];
         end
      end

      assign valid_st[i+1] = valid_ff;
      assign side_st[i+1]  = side_ff;
      for (genvar l = 0; l < LANES; l++) begin : g_lane
         assign x_st[i+1][l] = x_ff[l];
         assign y_st[i+1][l] = y_ff[l];
         assign z_st[i+1][l] = z_ff[l];
      end
   end

   assign out_valid = valid_st[ITER];
   assign out_side  = side_st[ITER];

endmodule

// ===== hw/rtl/leg_inverse_kinematics.sv =====
// leg_inverse_kinematics: top level of the two-link leg inverse kinematics pipeline
// depends on lik_pkg, lik_isqrt, lik_div and lik_cordic
//
// One request gives a leg number and a foot target (x, z) in signed q8.8; one response
// gives both motor angles in q23.8 degrees times the gear ratio, with a flag for any
// clamping. The datapath is a fixed pipeline of 61 + ANGLE_ITERATIONS stages: a 16 cell
// square root for the leg length, a 17 cell two-lane divider for the asin and acos
// ratios, a 17 cell two-lane square root and an ANGLE_ITERATIONS cell two-lane cordic,
// so a new request is taken every cycle unless held. The whole pipeline holds while
// a response waits under rsp_stall. The user must write the registers only while no
// request is in flight, which the block does not enforce; csr_ready is always high.
module leg_inverse_kinematics #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  lik_pkg::req_payload_type  req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output lik_pkg::rsp_payload_type  rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [lik_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]               csr_data
);
   import lik_pkg::*;

   localparam int XW = 20;
   localparam int ZW = 24;
   localparam int TW = 27;
   localparam int DW = 33;
   localparam logic [33:0]          ONE_SQ     = 34'h1_0000_0000;
   localparam logic signed [TW-1:0] NINETY_DEG = 27'sd5898240;

   logic en;

   // configuration
   logic [15:0] upper_link_ff, lower_link_ff, min_length_ff, max_length_ff, gear_ratio_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         upper_link_ff <= 16'd3840;
         lower_link_ff <= 16'd3840;
         min_length_ff <= 16'd2560;
         max_length_ff <= 16'd7424;
         gear_ratio_ff <= 16'd256;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_UPPER_LINK: upper_link_ff <= csr_data;
            CSR_LOWER_LINK: lower_link_ff <= csr_data;
            CSR_MIN_LENGTH: min_length_ff <= csr_data;
            CSR_MAX_LENGTH: max_length_ff <= csr_data;
            CSR_GEAR_RATIO: gear_ratio_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic [15:0] l1_eff;
   assign l1_eff = (upper_link_ff == 16'd0) ? 16'd1 : upper_link_ff;

   // flow control
   logic                  rsp_valid_ff;
   rsp_payload_type       rsp_payload_ff;

   assign en          = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = !en;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // squares of the target
   logic signed [31:0] xx_prod, zz_prod;
   logic               a_valid_ff;
   logic [30:0]        a_xx_ff, a_zz_ff;
   logic [1:0]         a_leg_ff;
   logic signed [15:0] a_x_ff;

   assign xx_prod = req_payload.x_pos * req_payload.x_pos;
   assign zz_prod = req_payload.z_pos * req_payload.z_pos;

   logic               b_valid_ff;
   logic [31:0]        b_sum_ff;
   logic [1:0]         b_leg_ff;
   logic signed [15:0] b_x_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_valid;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_xx_ff  <= xx_prod[30:0];
         a_zz_ff  <= zz_prod[30:0];
         a_leg_ff <= req_payload.leg_select;
         a_x_ff   <= req_payload.x_pos;
         b_sum_ff <= {1'b0, a_xx_ff} + {1'b0, a_zz_ff};
         b_leg_ff <= a_leg_ff;
         b_x_ff   <= a_x_ff;
      end
   end

   // leg length
   logic              len_valid;
   logic [0:0][15:0]  len_root;
   logic [17:0]       len_side;

   lik_isqrt #(.LANES(1), .IW(32), .SW(18)) u_len_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (b_valid_ff),
      .in_rad    (b_sum_ff),
      .in_side   ({b_leg_ff, b_x_ff}),
      .out_valid (len_valid),
      .out_root  (len_root),
      .out_side  (len_side)
   );

   // clamp
   logic [15:0]        c_len_in;
   logic               c_sat_in;
   logic               c_valid_ff;
   logic [15:0]        c_len_ff;
   logic               c_sat_ff;
   logic [1:0]         c_leg_ff;
   logic signed [15:0] c_x_ff;

   always_comb begin
      c_len_in = len_root[0];
      c_sat_in = 1'b0;
      if (c_len_in < min_length_ff) begin
         c_len_in = min_length_ff;
         c_sat_in = 1'b1;
      end
      if (c_len_in > max_length_ff) begin
         c_len_in = max_length_ff;
         c_sat_in = 1'b1;
      end
      if (c_len_in == 16'd0) begin
         c_len_in = 16'd1;
         c_sat_in = 1'b1;
      end
   end

   // link products
   logic        d_valid_ff;
   logic [31:0] d_ll_ff, d_l1sq_ff, d_l2sq_ff, d_l1l_ff;
   logic [15:0] d_len_ff, d_xmag_ff;
   logic        d_xneg_ff, d_sat_ff;
   logic [1:0]  d_leg_ff;

   // ratio operands
   logic signed [33:0]        e_num;
   logic                      e_valid_ff;
   logic [1:0][DW-1:0]        e_mag_ff, e_den_ff;
   logic                      e_xneg_ff, e_cneg_ff, e_sat_ff;
   logic [1:0]                e_leg_ff;

   assign e_num = 34'(d_ll_ff) + 34'(d_l1sq_ff) - 34'(d_l2sq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else if (en) begin
         c_valid_ff <= len_valid;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_len_ff    <= c_len_in;
         c_sat_ff    <= c_sat_in;
         c_leg_ff    <= len_side[17:16];
         c_x_ff      <= len_side[15:0];
         d_ll_ff     <= c_len_ff * c_len_ff;
         d_l1sq_ff   <= l1_eff * l1_eff;
         d_l2sq_ff   <= lower_link_ff * lower_link_ff;
         d_l1l_ff    <= l1_eff * c_len_ff;
         d_len_ff    <= c_len_ff;
         d_xmag_ff   <= c_x_ff[15] ? 16'(-c_x_ff) : c_x_ff;
         d_xneg_ff   <= c_x_ff[15];
         d_sat_ff    <= c_sat_ff;
         d_leg_ff    <= c_leg_ff;
         e_mag_ff[0] <= DW'(d_xmag_ff);
         e_den_ff[0] <= DW'(d_len_ff);
         e_mag_ff[1] <= e_num[33] ? DW'(-e_num) : e_num[DW-1:0];
         e_den_ff[1] <= {d_l1l_ff, 1'b0};
         e_xneg_ff   <= d_xneg_ff;
         e_cneg_ff   <= e_num[33];
         e_sat_ff    <= d_sat_ff;
         e_leg_ff    <= d_leg_ff;
      end
   end

   // asin and acos ratios
   logic                         div_valid;
   logic [1:0][QUOT_WIDTH-1:0]   div_quot;
   logic [1:0]                   div_ovf;
   logic [4:0]                   div_side;

   lik_div #(.LANES(2), .W(DW), .SW(5)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid_ff),
      .in_mag    (e_mag_ff),
      .in_den    (e_den_ff),
      .in_side   ({e_leg_ff, e_sat_ff, e_xneg_ff, e_cneg_ff}),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_ovf   (div_ovf),
      .out_side  (div_side)
   );

   logic [1:0]                  q_sat;
   logic [1:0][QUOT_WIDTH-1:0]  q_val;
   logic signed [17:0]          s_in, c_in;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         q_sat[l] = div_ovf[l] || (div_quot[l] > ONE_Q16);
         q_val[l] = q_sat[l] ? ONE_Q16 : div_quot[l];
      end
      s_in = 18'(q_val[0]);
      c_in = 18'(q_val[1]);
      if (div_side[1]) begin
         s_in = -s_in;
      end
      if (div_side[0]) begin
         c_in = -c_in;
      end
   end

   logic               f_valid_ff;
   logic signed [17:0] f_s_ff, f_c_ff;
   logic               f_sat_ff;
   logic [1:0]         f_leg_ff;

   logic signed [35:0] ssq, csq;
   assign ssq = f_s_ff * f_s_ff;
   assign csq = f_c_ff * f_c_ff;

   logic               g_valid_ff;
   logic [1:0][33:0]   g_rad_ff;
   logic signed [17:0] g_s_ff, g_c_ff;
   logic               g_sat_ff;
   logic [1:0]         g_leg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
      end else if (en) begin
         f_valid_ff <= div_valid;
         g_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f_s_ff      <= s_in;
         f_c_ff      <= c_in;
         f_sat_ff    <= div_side[2] | q_sat[0] | q_sat[1];
         f_leg_ff    <= div_side[4:3];
         g_rad_ff[0] <= ONE_SQ - ssq[33:0];
         g_rad_ff[1] <= ONE_SQ - csq[33:0];
         g_s_ff      <= f_s_ff;
         g_c_ff      <= f_c_ff;
         g_sat_ff    <= f_sat_ff;
         g_leg_ff    <= f_leg_ff;
      end
   end

   // complementary legs of the unit triangles
   logic               w_valid;
   logic [1:0][16:0]   w_root;
   logic [38:0]        w_side;

   lik_isqrt #(.LANES(2), .IW(34), .SW(39)) u_unit_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid_ff),
      .in_rad    (g_rad_ff),
      .in_side   ({g_leg_ff, g_sat_ff, g_s_ff, g_c_ff}),
      .out_valid (w_valid),
      .out_root  (w_root),
      .out_side  (w_side)
   );

   logic signed [17:0] w_s, w_c;
   assign w_s = w_side[35:18];
   assign w_c = w_side[17:0];

   logic                 h_valid_ff;
   logic signed [XW-1:0] h_x_ff [2];
   logic signed [XW-1:0] h_y_ff [2];
   logic                 h_flag_ff, h_sat_ff;
   logic [1:0]           h_leg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
      end else if (en) begin
         h_valid_ff <= w_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_x_ff[0] <= XW'(w_root[0]);
         h_y_ff[0] <= XW'(w_s);
         if (!w_c[17]) begin
            h_x_ff[1] <= XW'(w_c);
            h_y_ff[1] <= XW'(w_root[1]);
         end else begin
            h_x_ff[1] <= XW'(w_root[1]);
            h_y_ff[1] <= XW'(-w_c);
         end
         h_flag_ff <= w_c[17];
         h_sat_ff  <= w_side[36];
         h_leg_ff  <= w_side[38:37];
      end
   end

   // psi and phi
   logic                 ang_valid;
   logic signed [ZW-1:0] ang_z [2];
   logic [3:0]           ang_side;

   lik_cordic #(.LANES(2), .ITER(ANGLE_ITERATIONS), .XW(XW), .ZW(ZW), .SW(4)) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (h_valid_ff),
      .in_x      (h_x_ff),
      .in_y      (h_y_ff),
      .in_side   ({h_leg_ff, h_sat_ff, h_flag_ff}),
      .out_valid (ang_valid),
      .out_z     (ang_z),
      .out_side  (ang_side)
   );

   logic signed [TW-1:0] psi, phi, th1, th2;
   logic                 right_leg;

   assign right_leg = ang_side[3];
   assign psi = TW'(ang_z[0]);
   assign phi = TW'(ang_z[1]) + (ang_side[0] ? NINETY_DEG : '0);
   assign th1 = phi + psi - NINETY_DEG;
   assign th2 = phi - psi - NINETY_DEG;

   logic                 i_valid_ff;
   logic signed [TW-1:0] i_a_ff, i_b_ff;
   logic                 i_neg_ff, i_sat_ff;
   logic [1:0]           i_leg_ff;

   logic signed [43:0]   pa, pb;
   assign pa = i_a_ff * $signed({1'b0, gear_ratio_ff});
   assign pb = i_b_ff * $signed({1'b0, gear_ratio_ff});

   logic                 j_valid_ff;
   logic signed [43:0]   j_pa_ff, j_pb_ff;
   logic                 j_neg_ff, j_sat_ff;
   logic [1:0]           j_leg_ff;

   // gear scaling, sign for right legs, rounding to q.8
   logic signed [44:0] va, vb, ra, rb;

   always_comb begin
      va = 45'(j_pa_ff);
      vb = 45'(j_pb_ff);
      if (j_neg_ff) begin
         va = -va;
         vb = -vb;
      end
      ra = (va + 45'sd32768) >>> 16;
      rb = (vb + 45'sd32768) >>> 16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff   <= 1'b0;
         j_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         i_valid_ff   <= ang_valid;
         j_valid_ff   <= i_valid_ff;
         rsp_valid_ff <= j_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         i_a_ff   <= right_leg ? th2 : th1;
         i_b_ff   <= right_leg ? th1 : th2;
         i_neg_ff <= right_leg;
         i_sat_ff <= ang_side[1];
         i_leg_ff <= ang_side[3:2];
         j_pa_ff  <= pa;
         j_pb_ff  <= pb;
         j_neg_ff <= i_neg_ff;
         j_sat_ff <= i_sat_ff;
         j_leg_ff <= i_leg_ff;
         rsp_payload_ff.leg_number   <= j_leg_ff;
         rsp_payload_ff.motor_first  <= 32'(ra);
         rsp_payload_ff.motor_second <= 32'(rb);
         rsp_payload_ff.saturated    <= j_sat_ff;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while response held");

   assert property (@(posedge clock) disable iff (reset)
      c_valid_ff |-> c_len_ff != 16'd0)
      else $error("clamped leg length is zero");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && gear_ratio_ff == 16'd0 |->
         rsp_payload.motor_first == 32'sd0 && rsp_payload.motor_second == 32'sd0)
      else $error("motor angle nonzero with zero gear ratio");

endmodule
